/* src/sgrd_pkg.sv */
// shared types and constants for the sgr rendition decoder
package sgrd_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned ATTR_W  = 5;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COLOR_W = 3 * BYTE_W;

  localparam logic [MODE_W-1:0] MODE_DEFAULT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INDEX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGB     = 2'd2;

  localparam int unsigned BOLD_POS    = 0;
  localparam int unsigned ULINE_POS   = 1;
  localparam int unsigned BLINK_POS   = 2;
  localparam int unsigned REVERSE_POS = 3;
  localparam int unsigned HIDE_POS    = 4;

  localparam logic [VALUE_W-1:0] SEL_INDEX = 16'd5;
  localparam logic [VALUE_W-1:0] SEL_RGB   = 16'd2;

  localparam logic [VALUE_W-1:0] CODE_RESET        = 16'd0;
  localparam logic [VALUE_W-1:0] CODE_BOLD         = 16'd1;
  localparam logic [VALUE_W-1:0] CODE_UNDERLINE    = 16'd4;
  localparam logic [VALUE_W-1:0] CODE_BLINK        = 16'd5;
  localparam logic [VALUE_W-1:0] CODE_INVERT       = 16'd7;
  localparam logic [VALUE_W-1:0] CODE_INVISIBLE    = 16'd8;
  localparam logic [VALUE_W-1:0] CODE_NO_BOLD      = 16'd22;
  localparam logic [VALUE_W-1:0] CODE_NO_UNDERLINE = 16'd24;
  localparam logic [VALUE_W-1:0] CODE_NO_BLINK     = 16'd25;
  localparam logic [VALUE_W-1:0] CODE_NO_INVERT    = 16'd27;
  localparam logic [VALUE_W-1:0] CODE_NO_INVISIBLE = 16'd28;
  localparam logic [VALUE_W-1:0] CODE_FG_BASE      = 16'd30;
  localparam logic [VALUE_W-1:0] CODE_FG_EXT       = 16'd38;
  localparam logic [VALUE_W-1:0] CODE_FG_DEFAULT   = 16'd39;
  localparam logic [VALUE_W-1:0] CODE_BG_BASE      = 16'd40;
  localparam logic [VALUE_W-1:0] CODE_BG_EXT       = 16'd48;
  localparam logic [VALUE_W-1:0] CODE_BG_DEFAULT   = 16'd49;
  localparam logic [VALUE_W-1:0] CODE_FG_BRIGHT    = 16'd90;
  localparam logic [VALUE_W-1:0] CODE_BG_BRIGHT    = 16'd100;
  localparam logic [VALUE_W-1:0] COLOR_SPAN        = 16'd8;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr_bits;
    logic [MODE_W-1:0] fg_mode;
    logic [BYTE_W-1:0] fg_index;
    logic [BYTE_W-1:0] fg_red;
    logic [BYTE_W-1:0] fg_green;
    logic [BYTE_W-1:0] fg_blue;
    logic [MODE_W-1:0] bg_mode;
    logic [BYTE_W-1:0] bg_index;
    logic [BYTE_W-1:0] bg_red;
    logic [BYTE_W-1:0] bg_green;
    logic [BYTE_W-1:0] bg_blue;
    logic              seq_error;
  } rend_t;

endpackage

/* src/sgrd_in_stage.sv */
// input register stage for parameter beats
module sgrd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sgrd_pkg::in_beat_t in_beat,
  output logic             s1_valid,
  input  logic             s1_ready,
  output sgrd_pkg::in_beat_t s1_beat
);
  import sgrd_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  assign in_ready = !valid_r || s1_ready;
  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

/* src/sgrd_core.sv */
// rendition state, parameter decode and result register
module sgrd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  sgrd_pkg::in_beat_t s1_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output sgrd_pkg::rend_t    out_data
);
  import sgrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEL     = 3'd1,
    PH_IDX     = 3'd2,
    PH_RED     = 3'd3,
    PH_GREEN   = 3'd4,
    PH_BLUE    = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  logic [ATTR_W-1:0]   attr_r, attr_nxt;
  logic [MODE_W-1:0]   fg_kind_r, fg_kind_nxt, bg_kind_r, bg_kind_nxt;
  logic [COLOR_W-1:0]  fg_val_r, fg_val_nxt, bg_val_r, bg_val_nxt;
  phase_t              phase_r, phase_nxt;
  logic                back_r, back_nxt;
  logic [2*BYTE_W-1:0] part_rgb_r, part_rgb_nxt;
  logic                out_valid_r;
  rend_t               out_r, out_nxt;
  logic                adv;
  logic                err;
  logic [VALUE_W-1:0]  v;
  logic                last;
  logic [BYTE_W-1:0]   vb;
  logic                set_c;
  logic                set_back;
  logic [MODE_W-1:0]   set_kind;
  logic [COLOR_W-1:0]  set_val;

  assign s1_ready  = !out_valid_r || out_ready;
  assign adv       = s1_valid && s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign v         = s1_beat.value;
  assign last      = s1_beat.last;
  assign vb        = v[BYTE_W-1:0];

  always_comb begin
    attr_nxt     = attr_r;
    fg_kind_nxt  = fg_kind_r;
    fg_val_nxt   = fg_val_r;
    bg_kind_nxt  = bg_kind_r;
    bg_val_nxt   = bg_val_r;
    back_nxt     = back_r;
    part_rgb_nxt = part_rgb_r;
    phase_nxt    = PH_IDLE;
    err          = 1'b0;
    set_c        = 1'b0;
    set_back     = back_r;
    set_kind     = MODE_DEFAULT;
    set_val      = '0;

    unique case (phase_r)
      PH_SEL: begin
        if (last) begin
          err = 1'b1;
        end else if (v == SEL_INDEX) begin
          phase_nxt = PH_IDX;
        end else if (v == SEL_RGB) begin
          phase_nxt = PH_RED;
        end else begin
          err = 1'b1;
        end
      end
      PH_IDX: begin
        set_c    = 1'b1;
        set_kind = MODE_INDEX;
        set_val  = {{(COLOR_W-BYTE_W){1'b0}}, vb};
      end
      PH_RED: begin
        if (last) begin
          err = 1'b1;
        end else begin
          part_rgb_nxt = {vb, {BYTE_W{1'b0}}};
          phase_nxt    = PH_GREEN;
        end
      end
      PH_GREEN: begin
        if (last) begin
          err = 1'b1;
        end else begin
          part_rgb_nxt = {part_rgb_r[2*BYTE_W-1:BYTE_W], vb};
          phase_nxt    = PH_BLUE;
        end
      end
      PH_BLUE: begin
        set_c    = 1'b1;
        set_kind = MODE_RGB;
        set_val  = {part_rgb_r, vb};
      end
      PH_DISCARD: begin
        if (!last) begin
          phase_nxt = PH_DISCARD;
        end
      end
      default: begin
        priority if (v == CODE_RESET) begin
          attr_nxt    = '0;
          fg_kind_nxt = MODE_DEFAULT;
          fg_val_nxt  = '0;
          bg_kind_nxt = MODE_DEFAULT;
          bg_val_nxt  = '0;
        end else if (v == CODE_BOLD) begin
          attr_nxt[BOLD_POS] = 1'b1;
        end else if (v == CODE_UNDERLINE) begin
          attr_nxt[ULINE_POS] = 1'b1;
        end else if (v == CODE_BLINK) begin
          attr_nxt[BLINK_POS] = 1'b1;
        end else if (v == CODE_INVERT) begin
          attr_nxt[REVERSE_POS] = 1'b1;
        end else if (v == CODE_INVISIBLE) begin
          attr_nxt[HIDE_POS] = 1'b1;
        end else if (v == CODE_NO_BOLD) begin
          attr_nxt[BOLD_POS] = 1'b0;
        end else if (v == CODE_NO_UNDERLINE) begin
          attr_nxt[ULINE_POS] = 1'b0;
        end else if (v == CODE_NO_BLINK) begin
          attr_nxt[BLINK_POS] = 1'b0;
        end else if (v == CODE_NO_INVERT) begin
          attr_nxt[REVERSE_POS] = 1'b0;
        end else if (v == CODE_NO_INVISIBLE) begin
          attr_nxt[HIDE_POS] = 1'b0;
        end else if (v >= CODE_FG_BASE && v < CODE_FG_BASE + COLOR_SPAN) begin
          set_c    = 1'b1;
          set_back = 1'b0;
          set_kind = MODE_INDEX;
          set_val  = {{(COLOR_W-BYTE_W){1'b0}}, BYTE_W'(v - CODE_FG_BASE)};
        end else if (v == CODE_FG_DEFAULT) begin
          set_c    = 1'b1;
          set_back = 1'b0;
        end else if (v >= CODE_BG_BASE && v < CODE_BG_BASE + COLOR_SPAN) begin
          set_c    = 1'b1;
          set_back = 1'b1;
          set_kind = MODE_INDEX;
          set_val  = {{(COLOR_W-BYTE_W){1'b0}}, BYTE_W'(v - CODE_BG_BASE)};
        end else if (v == CODE_BG_DEFAULT) begin
          set_c    = 1'b1;
          set_back = 1'b1;
        end else if (v >= CODE_FG_BRIGHT && v < CODE_FG_BRIGHT + COLOR_SPAN) begin
          set_c    = 1'b1;
          set_back = 1'b0;
          set_kind = MODE_INDEX;
          set_val  = {{(COLOR_W-BYTE_W){1'b0}},
                      BYTE_W'(v - CODE_FG_BRIGHT + COLOR_SPAN)};
        end else if (v >= CODE_BG_BRIGHT && v < CODE_BG_BRIGHT + COLOR_SPAN) begin
          set_c    = 1'b1;
          set_back = 1'b1;
          set_kind = MODE_INDEX;
          set_val  = {{(COLOR_W-BYTE_W){1'b0}},
                      BYTE_W'(v - CODE_BG_BRIGHT + COLOR_SPAN)};
        end else if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
          back_nxt = (v == CODE_BG_EXT);
          if (last) begin
            err = 1'b1;
          end else begin
            phase_nxt = PH_SEL;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    if (set_c) begin
      if (set_back) begin
        bg_kind_nxt = set_kind;
        bg_val_nxt  = set_val;
      end else begin
        fg_kind_nxt = set_kind;
        fg_val_nxt  = set_val;
      end
    end

    if (err) begin
      attr_nxt    = '0;
      fg_kind_nxt = MODE_DEFAULT;
      fg_val_nxt  = '0;
      bg_kind_nxt = MODE_DEFAULT;
      bg_val_nxt  = '0;
      phase_nxt   = last ? PH_IDLE : PH_DISCARD;
    end

    out_nxt.attr_bits = attr_nxt;
    out_nxt.fg_mode   = fg_kind_nxt;
    out_nxt.fg_index  = (fg_kind_nxt == MODE_INDEX) ? fg_val_nxt[BYTE_W-1:0] : '0;
    out_nxt.fg_red    = (fg_kind_nxt == MODE_RGB) ? fg_val_nxt[3*BYTE_W-1:2*BYTE_W] : '0;
    out_nxt.fg_green  = (fg_kind_nxt == MODE_RGB) ? fg_val_nxt[2*BYTE_W-1:BYTE_W] : '0;
    out_nxt.fg_blue   = (fg_kind_nxt == MODE_RGB) ? fg_val_nxt[BYTE_W-1:0] : '0;
    out_nxt.bg_mode   = bg_kind_nxt;
    out_nxt.bg_index  = (bg_kind_nxt == MODE_INDEX) ? bg_val_nxt[BYTE_W-1:0] : '0;
    out_nxt.bg_red    = (bg_kind_nxt == MODE_RGB) ? bg_val_nxt[3*BYTE_W-1:2*BYTE_W] : '0;
    out_nxt.bg_green  = (bg_kind_nxt == MODE_RGB) ? bg_val_nxt[2*BYTE_W-1:BYTE_W] : '0;
    out_nxt.bg_blue   = (bg_kind_nxt == MODE_RGB) ? bg_val_nxt[BYTE_W-1:0] : '0;
    out_nxt.seq_error = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= '0;
      fg_kind_r   <= MODE_DEFAULT;
      fg_val_r    <= '0;
      bg_kind_r   <= MODE_DEFAULT;
      bg_val_r    <= '0;
      phase_r     <= PH_IDLE;
      back_r      <= 1'b0;
      part_rgb_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        out_valid_r <= s1_valid;
      end
      if (adv) begin
        attr_r     <= attr_nxt;
        fg_kind_r  <= fg_kind_nxt;
        fg_val_r   <= fg_val_nxt;
        bg_kind_r  <= bg_kind_nxt;
        bg_val_r   <= bg_val_nxt;
        phase_r    <= phase_nxt;
        back_r     <= back_nxt;
        part_rgb_r <= part_rgb_nxt;
      end
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.seq_error |->
      out_r.attr_bits == '0 && out_r.fg_mode == MODE_DEFAULT && out_r.bg_mode == MODE_DEFAULT)
    else $error("error beat did not clear rendition");
  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last |=> phase_r == PH_IDLE)
    else $error("sequence end left decoder mid-sequence");
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    fg_kind_r <= MODE_RGB && bg_kind_r <= MODE_RGB)
    else $error("illegal colour mode");
  a_fg_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fg_mode != MODE_RGB |->
      out_r.fg_red == '0 && out_r.fg_green == '0 && out_r.fg_blue == '0)
    else $error("rgb fields leak outside rgb mode");
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(adv) |-> out_r.attr_bits == attr_r && out_r.bg_mode == bg_kind_r)
    else $error("result register out of step with state");
`endif

endmodule

/* src/sgr_rendition_decoder.sv */
// top level of the sgr rendition decoder
// a parameter beat is held in the input register stage, then its result in the core's result register
// throughput: one parameter beat per cycle while the result register is empty or drains, set by the state update
// in_ready stays high while the result register drains or is empty
// reset (rst_n low, synchronous): attributes clear, both colours default, decoder idle
// no clearing pass after reset; beats are taken on the first cycle after it
module sgr_rendition_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_param_value,
  input  logic        in_last_param,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_attr_bits,
  output logic [1:0]  out_fg_mode,
  output logic [7:0]  out_fg_index,
  output logic [7:0]  out_fg_red,
  output logic [7:0]  out_fg_green,
  output logic [7:0]  out_fg_blue,
  output logic [1:0]  out_bg_mode,
  output logic [7:0]  out_bg_index,
  output logic [7:0]  out_bg_red,
  output logic [7:0]  out_bg_green,
  output logic [7:0]  out_bg_blue,
  output logic        out_seq_error
);
  import sgrd_pkg::*;

  in_beat_t in_beat;
  in_beat_t s1_beat;
  logic     s1_valid;
  logic     s1_ready;
  rend_t    out_data;

  assign in_beat.value = in_param_value;
  assign in_beat.last  = in_last_param;

  sgrd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_beat  (s1_beat)
  );

  sgrd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_beat   (s1_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_attr_bits = out_data.attr_bits;
  assign out_fg_mode   = out_data.fg_mode;
  assign out_fg_index  = out_data.fg_index;
  assign out_fg_red    = out_data.fg_red;
  assign out_fg_green  = out_data.fg_green;
  assign out_fg_blue   = out_data.fg_blue;
  assign out_bg_mode   = out_data.bg_mode;
  assign out_bg_index  = out_data.bg_index;
  assign out_bg_red    = out_data.bg_red;
  assign out_bg_green  = out_data.bg_green;
  assign out_bg_blue   = out_data.bg_blue;
  assign out_seq_error = out_data.seq_error;

endmodule
